FILE: hw/rtl/ngc_pkg.sv
package ngc_pkg;

    localparam int MAX_DIMS = 4;
    localparam int ID_WIDTH = 32;
    localparam int SIZE_W   = 16;
    localparam int COORD_W  = 32;
    localparam int DIMS_W   = 3;
    localparam int TOTAL_W  = 64;
    localparam int IDX_W    = 2;
    localparam int NDIV     = MAX_DIMS - 1;
    localparam int NSTAGE   = NDIV * ID_WIDTH;

    // one pipeline slot of the chained restoring dividers
    typedef struct packed {
        logic [ID_WIDTH-1:0]            q;
        logic [SIZE_W-1:0]              r;
        logic [NDIV-1:0][SIZE_W-1:0]    rem;
        logic [NDIV-1:0][ID_WIDTH-1:0]  quo;
    } stage_t;

    // a size of zero counts as one
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        eff_size = (s == '0) ? SIZE_W'(1) : s;
    endfunction

endpackage

FILE: hw/rtl/ngc_if.sv
interface ngc_in_if;
    logic                          valid;
    logic                          ready;
    logic [ngc_pkg::ID_WIDTH-1:0]  node_id;

    modport source (output valid, output node_id, input ready);
    modport sink   (input valid, input node_id, output ready);
endinterface

interface ngc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ngc_pkg::COORD_W-1:0]   coord0;
    logic [ngc_pkg::COORD_W-1:0]   coord1;
    logic [ngc_pkg::COORD_W-1:0]   coord2;
    logic [ngc_pkg::COORD_W-1:0]   coord3;
    logic [ngc_pkg::DIMS_W-1:0]    active_dims;
    logic [ngc_pkg::TOTAL_W-1:0]   total_nodes;

    modport source (output valid, output coord0, output coord1, output coord2,
                    output coord3, output active_dims, output total_nodes, input ready);
    modport sink   (input valid, input coord0, input coord1, input coord2,
                    input coord3, input active_dims, input total_nodes, output ready);
endinterface

FILE: hw/rtl/node_id_to_grid_coordinates_top.sv
// channel  | dir | payload                                          | handshake
// in_ch    | in  | node_id                                          | valid/ready
// out_ch   | out | coord0..coord3, active_dims, total_nodes         | valid/ready
// cfg      | in  | cfg_index, cfg_wdata                             | cfg_we
//
// one request per cycle while the output does not stall; 96 register stages, one quotient bit per stage,
// through three chained 32-bit restoring dividers (by size 0, 1 and 2)
// an accepted request steps through the stages in order and is offered from the last one
// the last divider stage is the output register; a stall freezes the whole pipeline
// rst_n clears the valid bits and sets every size to one; payload is not reset
module node_id_to_grid_coordinates_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ngc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ngc_pkg::SIZE_W-1:0]   cfg_wdata,
    ngc_in_if.sink                       in_ch,
    ngc_out_if.source                    out_ch
);

    localparam int NS = ngc_pkg::NSTAGE;
    localparam int IW = ngc_pkg::ID_WIDTH;
    localparam int SW = ngc_pkg::SIZE_W;
    localparam int ND = ngc_pkg::NDIV;
    localparam int MD = ngc_pkg::MAX_DIMS;

    // configuration registers
    logic [MD-1:0][SW-1:0] size_reg;
    logic [MD-1:0][SW-1:0] eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MD; i++)
            begin
                size_reg[i] <= SW'(1);
            end
        end
        else if (cfg_we)
        begin
            size_reg[cfg_index] <= cfg_wdata;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MD; i++)
        begin
            eff[i] = ngc_pkg::eff_size(size_reg[i]);
        end
    end

    // division j really divides only below the top dimension; at or above it
    // the divisor is one, so the top quotient passes through unreduced
    logic [ND-1:0] div_on;

    always_comb
    begin
        div_on = '0;
        for (int j = 0; j < ND; j++)
        begin
            for (int i = j + 1; i < MD; i++)
            begin
                if (eff[i] != SW'(1))
                begin
                    div_on[j] = 1'b1;
                end
            end
        end
    end

    // derived grid values: active_reg is registered from eff, total_reg from p01_reg and
    // p23_reg; they settle after a write long before a request accepted after it reaches the output
    logic [ngc_pkg::DIMS_W-1:0]  active_next, active_reg;
    logic [2*SW-1:0]             p01_reg, p23_reg;
    logic [ngc_pkg::TOTAL_W-1:0] total_reg;

    always_comb
    begin
        active_next = ngc_pkg::DIMS_W'(1);
        for (int i = 0; i < MD; i++)
        begin
            if (eff[i] != SW'(1))
            begin
                active_next = ngc_pkg::DIMS_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        active_reg <= active_next;
        p01_reg    <= eff[0] * eff[1];
        p23_reg    <= eff[2] * eff[3];
        total_reg  <= p01_reg * p23_reg;
    end

    // divider pipeline: stage k does step k%IW (quotient bit IW-1-k%IW) of division k/IW
    logic                  advance;
    logic [NS-1:0]         vld_reg;
    ngc_pkg::stage_t       st_reg  [NS];
    ngc_pkg::stage_t       st_next [NS];

    assign advance     = !vld_reg[NS-1] || out_ch.ready;
    assign in_ch.ready = advance;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam int J = k / IW;
        localparam int B = k % IW;
        ngc_pkg::stage_t  prev;
        logic [SW-1:0]    dvs;
        logic [SW:0]      trial;
        logic             qbit;

        always_comb
        begin
            if (k == 0)
            begin
                prev   = '0;
                prev.q = in_ch.node_id;
            end
            else
            begin
                prev = st_reg[(k == 0) ? 0 : k-1];
            end
            if (B == 0)
            begin
                prev.r = '0;
            end
            dvs        = div_on[J] ? eff[J] : SW'(1);
            trial      = {prev.r, prev.q[IW-1]};
            qbit       = (trial >= {1'b0, dvs});
            st_next[k] = prev;
            st_next[k].r = qbit ? SW'(trial - {1'b0, dvs}) : trial[SW-1:0];
            st_next[k].q = {prev.q[IW-2:0], qbit};
            if (B == IW-1)
            begin
                st_next[k].rem[J] = st_next[k].r;
                st_next[k].quo[J] = st_next[k].q;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= (k == 0) ? in_ch.valid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // final selection: digits below the top dimension, the unreduced quotient
    // at the top, zero above
    logic [MD-1:0][ngc_pkg::COORD_W-1:0] coord;
    ngc_pkg::stage_t                      last;
    logic [ngc_pkg::DIMS_W-1:0]           top;

    assign last = st_reg[NS-1];
    assign top  = active_reg - ngc_pkg::DIMS_W'(1);

    always_comb
    begin
        for (int d = 0; d < MD; d++)
        begin
            if (ngc_pkg::DIMS_W'(d) < top)
            begin
                coord[d] = ngc_pkg::COORD_W'(last.rem[(d < ND) ? d : 0]);
            end
            else if (ngc_pkg::DIMS_W'(d) == top)
            begin
                coord[d] = (d == 0) ? last.quo[0] : last.quo[(d == 0) ? 0 : d-1];
            end
            else
            begin
                coord[d] = '0;
            end
        end
    end

    assign out_ch.valid       = vld_reg[NS-1];
    assign out_ch.coord0      = coord[0];
    assign out_ch.coord1      = coord[1];
    assign out_ch.coord2      = coord[2];
    assign out_ch.coord3      = coord[3];
    assign out_ch.active_dims = active_reg;
    assign out_ch.total_nodes = total_reg;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input stalled with empty output stage");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> vld_reg[0])
        else $error("accepted request did not enter first stage");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && active_reg != ngc_pkg::DIMS_W'(4) |-> out_ch.coord3 == '0)
        else $error("inactive coordinate not zero");

    a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> active_reg != '0)
        else $error("active dimension count is zero");

endmodule
